[src/cfdf_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the footer deframer.
// No dependencies; every other file of the block imports this package.
package cfdf_pkg;

   localparam int ByteWidth  = 8;
   localparam int CountWidth = 12;
   localparam int CrcWidth   = 16;
   localparam int StatWidth  = 32;

   localparam logic [CrcWidth-1:0]   CrcPoly          = 16'h1021;
   localparam logic [31:0]           HeaderWord       = 32'hDDCCBBAA;
   localparam logic [31:0]           FooterWord       = 32'hAABBCCDD;
   localparam logic [CountWidth-1:0] MinPayloadReset  = 12'd700;
   localparam logic [CountWidth-1:0] MaxBufferedReset = 12'd1287;
   // Depth of the tail window that holds back the CRC and footer bytes.
   localparam logic [CountWidth-1:0] WindowDepth      = 12'd6;
   // Header plus footer bytes counted against the buffer limit.
   localparam logic [CountWidth:0]   FrameOverhead    = 13'd8;

   typedef enum logic [0:0] {
      CSR_MIN_LENGTH   = 1'b0,
      CSR_MAX_BUFFERED = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_ACCEPT   = 2'd1,
      EV_CRC_ERR  = 2'd2,
      EV_OVERFLOW = 2'd3
   } frame_event_type;

   typedef struct packed {
      logic [CountWidth-1:0] min_length;
      logic [CountWidth-1:0] max_buffered;
   } cfg_type;

   // One byte of CRC-16 with polynomial 0x1021, MSB first.
   function automatic logic [CrcWidth-1:0] crc16_byte(input logic [CrcWidth-1:0] crc,
                                                      input logic [ByteWidth-1:0] data);
      logic [CrcWidth-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[CrcWidth-1]) begin
            c = {c[CrcWidth-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[CrcWidth-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[src/cfdf_if.sv]
// Handshake channels of the footer deframer: received bytes, results, register writes.
// Depends on cfdf_pkg for widths and code types.
interface cfdf_req_if import cfdf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfdf_rsp_if import cfdf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  payload_valid;
   logic [ByteWidth-1:0]  payload_byte;
   logic [CountWidth-1:0] payload_index;
   logic [1:0]            frame_event;
   logic [CountWidth-1:0] payload_length;
   logic                  crc_big_endian;
   logic [StatWidth-1:0]  crc_error_count;
   logic [StatWidth-1:0]  frame_error_count;

   modport source (output valid, output payload_valid, output payload_byte,
                   output payload_index, output frame_event, output payload_length,
                   output crc_big_endian, output crc_error_count,
                   output frame_error_count, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input payload_index, input frame_event, input payload_length,
                   input crc_big_endian, input crc_error_count,
                   input frame_error_count, output ready);
endinterface

interface cfdf_csr_if import cfdf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CountWidth-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/cfdf_csr.sv]
// Configuration registers of the footer deframer: minimum payload and buffer limit.
// Depends on cfdf_pkg and the cfdf_csr_if channel.
module cfdf_csr import cfdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cfdf_csr_if.sink    csr_ch,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // Decode the register index; a write updates one field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MIN_LENGTH:   cfg_in.min_length   = csr_ch.data;
            CSR_MAX_BUFFERED: cfg_in.max_buffered = csr_ch.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length   <= MinPayloadReset;
         cfg_ff.max_buffered <= MaxBufferedReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/cfdf_deframe.sv]
// Deframer datapath: header hunt, tail window, CRC check, counters and result register.
// Depends on cfdf_pkg and the cfdf_rsp_if channel.
module cfdf_deframe import cfdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [ByteWidth-1:0] in_byte,
   input  cfg_type              cfg,
   output logic                 in_take,
   cfdf_rsp_if.source           rsp_ch
);

   // Frame state.
   logic [31:0]           hunt_ff, hunt_in;
   logic                  locked_ff, locked_in;
   logic [47:0]           tail_ff, tail_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CrcWidth-1:0]   crc_ff, crc_in;
   logic [StatWidth-1:0]  crc_err_ff, crc_err_in;
   logic [StatWidth-1:0]  frame_err_ff, frame_err_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   logic                  out_pv_ff;
   logic [ByteWidth-1:0]  out_pb_ff;
   logic [CountWidth-1:0] out_pi_ff;
   frame_event_type       out_ev_ff;
   logic [CountWidth-1:0] out_plen_ff;
   logic                  out_big_ff;

   // Next result word.
   logic                  pv;
   logic [ByteWidth-1:0]  pb;
   logic [CountWidth-1:0] pi;
   frame_event_type       ev;
   logic [CountWidth-1:0] plen;
   logic                  big;

   logic                  advance;
   logic                  fire;
   logic                  has_result;
   logic [31:0]           hunt_shift;
   logic [47:0]           tail_shift;
   logic [CountWidth-1:0] count_inc;
   logic                  window_full;
   logic [CrcWidth-1:0]   crc_mid;
   logic [CrcWidth-1:0]   crc_le;
   logic [CrcWidth-1:0]   crc_be;
   logic                  le_match;
   logic                  be_match;
   logic                  footer_check;
   logic                  over_limit;

   // A word is processed whenever the result register is free or being drained.
   assign advance    = !out_valid_ff || rsp_ch.ready;
   assign fire       = in_valid && advance;
   assign in_take    = advance;
   assign has_result = pv || (ev != EV_NONE);

   // Shifted windows and the CRC including the byte leaving the tail window.
   assign hunt_shift  = {hunt_ff[23:0], in_byte};
   assign tail_shift  = {tail_ff[39:0], in_byte};
   assign count_inc   = count_ff + 1'b1;
   assign window_full = count_ff >= WindowDepth;
   assign crc_mid     = window_full ? crc16_byte(crc_ff, tail_ff[47:40]) : crc_ff;

   // The two bytes ahead of the footer, read in both byte orders.
   assign crc_le   = {tail_shift[39:32], tail_shift[47:40]};
   assign crc_be   = {tail_shift[47:40], tail_shift[39:32]};
   assign le_match = crc_le == crc_mid;
   assign be_match = crc_be == crc_mid;

   assign footer_check = (count_inc >= WindowDepth) && (tail_shift[31:0] == FooterWord)
                         && ((count_inc - WindowDepth) >= cfg.min_length);
   assign over_limit   = ({1'b0, count_inc} + FrameOverhead) >= {1'b0, cfg.max_buffered};

   // Next state and result for one received word.
   always_comb begin
      hunt_in      = hunt_ff;
      locked_in    = locked_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      crc_err_in   = crc_err_ff;
      frame_err_in = frame_err_ff;
      pv           = 1'b0;
      pb           = '0;
      pi           = '0;
      ev           = EV_NONE;
      plen         = '0;
      big          = 1'b0;

      if (!locked_ff) begin
         // Hunting: lock when the last four bytes form the header.
         hunt_in = hunt_shift;
         if (hunt_shift == HeaderWord) begin
            locked_in = 1'b1;
            hunt_in   = '0;
            tail_in   = '0;
            count_in  = '0;
            crc_in    = '0;
         end
      end else begin
         pv       = window_full;
         pb       = window_full ? tail_ff[47:40] : '0;
         pi       = window_full ? (count_ff - WindowDepth) : '0;
         crc_in   = crc_mid;
         tail_in  = tail_shift;
         count_in = count_inc;

         if (footer_check) begin
            if (le_match || be_match) begin
               ev   = EV_ACCEPT;
               plen = count_inc - WindowDepth;
               big  = be_match && !le_match;
            end else begin
               ev         = EV_CRC_ERR;
               crc_err_in = crc_err_ff + 1'b1;
            end
         end

         // Buffer limit drops the frame unless it was just accepted.
         if (ev != EV_ACCEPT && over_limit) begin
            ev           = EV_OVERFLOW;
            frame_err_in = frame_err_ff + 1'b1;
         end

         // Back to hunting after an accepted or dropped frame.
         if (ev == EV_ACCEPT || ev == EV_OVERFLOW) begin
            locked_in = 1'b0;
            hunt_in   = '0;
            tail_in   = '0;
            count_in  = '0;
            crc_in    = '0;
         end
      end
   end

   // Result valid flag: loaded with a new result or cleared once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = has_result;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff      <= '0;
         locked_ff    <= 1'b0;
         tail_ff      <= '0;
         count_ff     <= '0;
         crc_ff       <= '0;
         crc_err_ff   <= '0;
         frame_err_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            hunt_ff      <= hunt_in;
            locked_ff    <= locked_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
            crc_ff       <= crc_in;
            crc_err_ff   <= crc_err_in;
            frame_err_ff <= frame_err_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         out_pv_ff   <= pv;
         out_pb_ff   <= pb;
         out_pi_ff   <= pi;
         out_ev_ff   <= ev;
         out_plen_ff <= plen;
         out_big_ff  <= big;
      end
   end

   // The counters only move on a processed word, so they stay with the held result.
   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.payload_valid     = out_pv_ff;
   assign rsp_ch.payload_byte      = out_pb_ff;
   assign rsp_ch.payload_index     = out_pi_ff;
   assign rsp_ch.frame_event       = out_ev_ff;
   assign rsp_ch.payload_length    = out_plen_ff;
   assign rsp_ch.crc_big_endian    = out_big_ff;
   assign rsp_ch.crc_error_count   = crc_err_ff;
   assign rsp_ch.frame_error_count = frame_err_ff;

`ifndef SYNTHESIS
   // A delivered word always carries a payload byte or an event.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_pv_ff || out_ev_ff != EV_NONE))
      else $error("result word without payload byte or event");

   // The byte order flag only accompanies an accepted frame.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_big_ff) |-> (out_ev_ff == EV_ACCEPT))
      else $error("byte order flag set without an accepted frame");

   // The CRC error counter steps by one at most.
   assert property (@(posedge clock) disable iff (reset)
      (crc_err_ff != $past(crc_err_ff)) |-> (crc_err_ff == $past(crc_err_ff) + 1'b1))
      else $error("CRC error counter jumped");

   // An accepted or dropped frame returns the block to hunting.
   assert property (@(posedge clock) disable iff (reset)
      (fire && locked_ff && (ev == EV_ACCEPT || ev == EV_OVERFLOW)) |=> !locked_ff)
      else $error("frame end did not unlock");
`endif

endmodule

[src/crc16_footer_deframer.sv]
// Top level of the CRC-16 footer deframer: input register and submodule wiring.
// Depends on cfdf_pkg, cfdf_if, cfdf_csr and cfdf_deframe.
//
// Usage:
//   req_ch carries one received byte per word. While hunting, the block looks for
//   the header DD CC BB AA; once locked, bytes pass a six-byte window and leave it
//   as tentative payload on rsp_ch, with their index. A footer AA BB CC DD behind a
//   payload of at least the configured minimum length triggers the CRC-16 check of
//   the two bytes ahead of it, in either byte order, reported on rsp_ch.frame_event.
//   csr_ch writes the minimum payload length (index 0) and max_buffered (index 1);
//   it is always ready and should only be written while no word is in flight.
//   Each byte is registered in the input register and then, with its result, in the
//   result register; words causing no result leave rsp_ch untouched.
//   Throughput: one byte per cycle unless a result word waits on rsp_ch.ready, set by
//   the single registered pass through the window, CRC update and footer compare.
//   Reset clears the frame state, both error counters and any pending word, and
//   restores the register defaults (700 and 1287).
//   When rsp_ch.ready is low, the result word holds, one more byte waits in the
//   input register, and req_ch.ready drops until the result is taken.
module crc16_footer_deframer import cfdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cfdf_req_if.sink    req_ch,
   cfdf_rsp_if.source  rsp_ch,
   cfdf_csr_if.sink    csr_ch
);

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_take;
   logic                 req_fire;
   cfg_type              cfg;

   // Input register: refilled whenever it is empty or its word moves on.
   assign req_ch.ready = !in_valid_ff || in_take;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   // Configuration registers.
   cfdf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Deframing datapath and result register.
   cfdf_deframe u_deframe (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_byte  (in_byte_ff),
      .cfg      (cfg),
      .in_take  (in_take),
      .rsp_ch   (rsp_ch)
   );

endmodule

[tb/sv/cfdf_deframe_checker.sv]
`timescale 1ns / 100ps
// Result checker for the CRC-16 footer deframer: watches the byte, result and register channels.
// Depends on cfdf_pkg and the channel interfaces in cfdf_if; predicts each result word and compares.
module cfdf_deframe_checker import cfdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cfdf_req_if         req_ch,
   cfdf_rsp_if         rsp_ch,
   cfdf_csr_if         csr_ch,
   output int unsigned mismatch_count,
   output int unsigned results_due
);

   // One expected result word, laid out as the result channel carries it.
   typedef struct packed {
      logic                  has_byte;
      logic [ByteWidth-1:0]  data;
      logic [CountWidth-1:0] index;
      frame_event_type       event_code;
      logic [CountWidth-1:0] length;
      logic                  big_endian;
      logic [StatWidth-1:0]  crc_fails;
      logic [StatWidth-1:0]  drops;
   } frame_result_type;

   // Register copies as last written.
   logic [CountWidth-1:0] cfg_min_len;
   logic [CountWidth-1:0] cfg_buf_limit;

   // Deframer state as seen from outside.
   logic [31:0]           sync_shift;
   logic                  in_frame;
   logic [47:0]           holdback;
   logic [CountWidth-1:0] rx_count;
   logic [CrcWidth-1:0]   crc_acc;
   logic [StatWidth-1:0]  crc_fail_tally;
   logic [StatWidth-1:0]  drop_tally;

   frame_result_type      due_words[$];
   frame_result_type      oldest;

   // Bit-serial CRC-16, MSB first, feeding one data bit per step.
   function automatic logic [CrcWidth-1:0] crc_shift_in(input logic [CrcWidth-1:0] crc,
                                                        input logic [ByteWidth-1:0] value);
      logic [CrcWidth-1:0] c;
      logic                fb;
      c = crc;
      for (int i = ByteWidth - 1; i >= 0; i--) begin
         fb = c[CrcWidth-1] ^ value[i];
         c  = {c[CrcWidth-2:0], 1'b0};
         if (fb) begin
            c = c ^ CrcPoly;
         end
      end
      return c;
   endfunction

   // Drop back to hunting with an empty window.
   function automatic void drop_frame();
      in_frame   = 1'b0;
      sync_shift = '0;
      holdback   = '0;
      rx_count   = '0;
      crc_acc    = '0;
   endfunction

   // Advance the state by one received byte and queue the result word it causes.
   function automatic void deframe_byte(input logic [ByteWidth-1:0] value);
      frame_result_type r;
      logic [CrcWidth-1:0] le_crc;
      logic [CrcWidth-1:0] be_crc;
      r = '0;
      r.event_code = EV_NONE;

      // Hunting: shift the byte in and lock on a complete header.
      if (!in_frame) begin
         sync_shift = {sync_shift[23:0], value};
         if (sync_shift == HeaderWord) begin
            drop_frame();
            in_frame = 1'b1;
         end
         return;
      end

      // The byte pushed out of a full window becomes tentative payload.
      if (rx_count >= WindowDepth) begin
         r.has_byte = 1'b1;
         r.data     = holdback[47:40];
         r.index    = rx_count - WindowDepth;
         crc_acc    = crc_shift_in(crc_acc, holdback[47:40]);
      end
      holdback = {holdback[39:0], value};
      rx_count = rx_count + 1'b1;

      // Footer behind a long enough payload: check the two bytes ahead of it.
      if (rx_count >= WindowDepth && holdback[31:0] == FooterWord &&
          rx_count - WindowDepth >= cfg_min_len) begin
         le_crc = {holdback[39:32], holdback[47:40]};
         be_crc = holdback[47:32];
         if (le_crc == crc_acc || be_crc == crc_acc) begin
            r.event_code = EV_ACCEPT;
            r.length     = rx_count - WindowDepth;
            r.big_endian = (be_crc == crc_acc) && (le_crc != crc_acc);
         end else begin
            r.event_code   = EV_CRC_ERR;
            crc_fail_tally = crc_fail_tally + 1'b1;
         end
      end

      // An accepted frame unlocks; otherwise the buffer limit may force a drop.
      if (r.event_code == EV_ACCEPT) begin
         drop_frame();
      end else if ({1'b0, rx_count} + FrameOverhead >= {1'b0, cfg_buf_limit}) begin
         r.event_code = EV_OVERFLOW;
         drop_tally   = drop_tally + 1'b1;
         drop_frame();
      end

      r.crc_fails = crc_fail_tally;
      r.drops     = drop_tally;
      if (r.has_byte || r.event_code != EV_NONE) begin
         due_words.push_back(r);
      end
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Register writes, byte words and result words, sampled at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         drop_frame();
         cfg_min_len    = MinPayloadReset;
         cfg_buf_limit  = MaxBufferedReset;
         crc_fail_tally = '0;
         drop_tally     = '0;
         mismatch_count = 0;
         due_words.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_MIN_LENGTH:   cfg_min_len   = csr_ch.data;
               CSR_MAX_BUFFERED: cfg_buf_limit = csr_ch.data;
               default:          ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.rx_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_words.size() == 0) begin
               $error("result word arrived with no expectation pending");
               mismatch_count++;
            end else begin
               oldest = due_words.pop_front();
               check_field("payload_valid", 32'(oldest.has_byte), 32'(rsp_ch.payload_valid));
               check_field("payload_byte", 32'(oldest.data), 32'(rsp_ch.payload_byte));
               check_field("payload_index", 32'(oldest.index), 32'(rsp_ch.payload_index));
               check_field("frame_event", 32'(oldest.event_code), 32'(rsp_ch.frame_event));
               check_field("payload_length", 32'(oldest.length), 32'(rsp_ch.payload_length));
               check_field("crc_big_endian", 32'(oldest.big_endian),
                           32'(rsp_ch.crc_big_endian));
               check_field("crc_error_count", oldest.crc_fails, rsp_ch.crc_error_count);
               check_field("frame_error_count", oldest.drops, rsp_ch.frame_error_count);
            end
         end
      end
      results_due <= 32'(due_words.size());
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Top of the footer deframer testbench: clock, reset, byte stimulus, register phases and verdict.
// Depends on cfdf_pkg, cfdf_if, crc16_footer_deframer and cfdf_deframe_checker.
module tb;
   import cfdf_pkg::*;

   localparam int TargetItems   = 1450;
   localparam int IdlePercent   = 20;
   localparam int FramesPerStep = 3;
   localparam int SettleCycles  = 4;

   logic        clock;
   logic        reset;
   logic        calm;
   int unsigned mismatch_count;
   int unsigned results_due;
   int unsigned bytes_sent;

   // Register values as last written, used to shape frames.
   logic [CountWidth-1:0] min_len;
   logic [CountWidth-1:0] buf_limit;

   // Bytes sent since the last header, the payload as the block sees it.
   logic [ByteWidth-1:0]  frame_bytes[$];

   cfdf_req_if req_ch ();
   cfdf_rsp_if rsp_ch ();
   cfdf_csr_if csr_ch ();

   crc16_footer_deframer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cfdf_deframe_checker u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well past the slowest correct run.
   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // The result side stalls at random unless a calm stretch is running.
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= IdlePercent);
   end

   // Send one byte word, with an occasional gap ahead of it.
   task automatic send_byte(input logic [ByteWidth-1:0] value);
      if (!calm && $urandom_range(99) < IdlePercent) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
      frame_bytes.push_back(value);
      bytes_sent++;
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_word(input logic [31:0] value);
      for (int i = 3; i >= 0; i--) begin
         send_byte(value[8*i +: 8]);
      end
   endtask

   task automatic send_header();
      send_word(HeaderWord);
      frame_bytes.delete();
   endtask

   // CRC-16 of everything sent since the header.
   function automatic logic [CrcWidth-1:0] frame_crc();
      logic [CrcWidth-1:0] c;
      c = '0;
      foreach (frame_bytes[i]) begin
         c = c ^ {frame_bytes[i], 8'h00};
         repeat (8) c = c[CrcWidth-1] ? ({c[CrcWidth-2:0], 1'b0} ^ CrcPoly)
                                      : {c[CrcWidth-2:0], 1'b0};
      end
      return c;
   endfunction

   // Two CRC bytes, right in the chosen order or wrong in both orders, then the footer.
   task automatic send_tail(input bit good, input bit big_order);
      logic [CrcWidth-1:0]  crc;
      logic [ByteWidth-1:0] c0;
      logic [ByteWidth-1:0] c1;
      crc = frame_crc();
      if (good) begin
         {c0, c1} = big_order ? crc : {crc[7:0], crc[15:8]};
      end else begin
         do {c0, c1} = 16'($urandom_range(0, 65535));
         while ({c1, c0} == crc || {c0, c1} == crc);
      end
      send_byte(c0);
      send_byte(c1);
      send_word(FooterWord);
   endtask

   // Wait until every expected result is in, then let any hunt byte drain.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Both registers are written back to back while the block is idle.
   task automatic write_config(input logic [CountWidth-1:0] min_value,
                               input logic [CountWidth-1:0] limit_value);
      settle();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_MIN_LENGTH;
      csr_ch.data  <= min_value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= CSR_MAX_BUFFERED;
      csr_ch.data  <= limit_value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      min_len   = min_value;
      buf_limit = limit_value;
   endtask

   // One frame: mostly well formed with random content, sometimes run into the buffer limit.
   task automatic random_frame();
      int unsigned overflow_at;
      int unsigned hi;
      int unsigned plen;
      int unsigned split;
      int unsigned short_len;
      send_random($urandom_range(0, 3));
      if ($urandom_range(9) == 0) begin
         // A partial header that the real one overlaps.
         send_byte(HeaderWord[31:24]);
         send_byte(HeaderWord[23:16]);
         send_byte(HeaderWord[15:8]);
      end
      overflow_at = (buf_limit > 9) ? buf_limit - 8 : 1;
      if (min_len + 14 > buf_limit || (buf_limit <= 300 && $urandom_range(99) < 15)) begin
         send_header();
         if (min_len > 0 && $urandom_range(1) == 1) begin
            // A good footer behind a payload that is still too short.
            short_len = $urandom_range(0, min_len - 1);
            if (short_len > overflow_at) short_len = overflow_at;
            send_random(short_len);
            send_tail(1'b1, 1'($urandom_range(1)));
         end
         if (frame_bytes.size() < overflow_at) begin
            send_random(overflow_at - frame_bytes.size());
         end
      end else begin
         hi = buf_limit - 14;
         if (hi > min_len + 40) hi = min_len + 40;
         plen = $urandom_range(min_len, hi);
         send_header();
         if (plen >= 6 && $urandom_range(99) < 20) begin
            // A bad CRC part way through; its bytes then count as payload.
            split = $urandom_range(0, plen - 6);
            send_random(split);
            send_tail(1'b0, 1'b0);
            send_random(plen - 6 - split);
         end else begin
            send_random(plen);
         end
         send_tail(1'b1, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int unsigned step;
      int unsigned m;
      reset          <= 1'b1;
      calm           <= 1'b0;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= CSR_MIN_LENGTH;
      csr_ch.data    <= '0;
      min_len   = MinPayloadReset;
      buf_limit = MaxBufferedReset;
      bytes_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: byte extremes, an overlapped header, a footer inside the
      // short window, then a frame at exactly the minimum payload.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HeaderWord[31:24]);
      send_byte(HeaderWord[23:16]);
      send_byte(HeaderWord[15:8]);
      send_header();
      send_word(FooterWord);
      send_random(MinPayloadReset - 4);
      send_tail(1'b1, 1'b0);

      // Empty payload: a zero CRC matches in both orders.
      write_config(12'd0, 12'd4095);
      send_header();
      send_tail(1'b1, 1'b1);

      // A CRC mismatch on the same byte that reaches the buffer limit.
      write_config(12'd0, 12'd16);
      send_header();
      send_random(2);
      send_tail(1'b0, 1'b0);

      // Random part: a new register setting per step, one step in six without idling.
      step = 0;
      while (bytes_sent < TargetItems || step < 6) begin
         case (step % 6)
            0: write_config(12'd0, 12'd4095);
            1: begin
               m = $urandom_range(0, 30);
               write_config(12'(m), 12'(m + $urandom_range(15, 74)));
            end
            2: write_config(12'd4095, 12'($urandom_range(16, 120)));
            3: write_config(12'd0, 12'($urandom_range(0, 15)));
            4: begin
               m = $urandom_range(0, 20);
               write_config(12'(m), 12'(m + $urandom_range(14, 34)));
            end
            default: begin
               m = $urandom_range(0, 60);
               write_config(12'(m), 12'(m + $urandom_range(14, 214)));
            end
         endcase
         calm <= (step % 6 == 4);
         repeat (FramesPerStep) random_frame();
         step++;
      end

      settle();
      if (mismatch_count == 0 && results_due == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
